// File: design/sdt_pkg.sv
// Shared widths, register map and pipeline types for the stereo triangulation block.
// Used by sdt_front, sdt_div_cell and stereo_disparity_triangulation.
package sdt_pkg;

	// field widths
	localparam int unsigned PIX_W   = 12;
	localparam int unsigned DISP_W  = 12;
	localparam int unsigned LVL_W   = 2;
	localparam int unsigned CTR_W   = 16;
	localparam int unsigned FOC_W   = 16;
	localparam int unsigned BASE_W  = 20;
	localparam int unsigned FL_W    = 3;
	localparam int unsigned COORD_W = 32;

	// scale exponent s = base-1+level, at most 6+3
	localparam int unsigned S_MAX = 9;
	localparam int unsigned S_W   = 4;

	// datapath widths
	localparam int unsigned DEN_W  = DISP_W + S_MAX;          // d << s
	localparam int unsigned MAG_W  = PIX_W + 4 + S_MAX;       // |u<<(4+s) - c|
	localparam int unsigned DIFF_W = MAG_W + 1;
	localparam int unsigned NUM_W  = MAG_W + BASE_W + 1;      // product plus rounding bias
	localparam int unsigned Q_W    = COORD_W + 2;             // two guard bits for saturation
	localparam int unsigned DIV_W  = DEN_W + Q_W;

	// configuration port
	localparam int unsigned ADDR_W = 5;
	localparam int unsigned APB_DW = 32;

	localparam logic [2:0] REG_CENTER_X    = 3'd0;
	localparam logic [2:0] REG_CENTER_Y    = 3'd1;
	localparam logic [2:0] REG_FOCAL       = 3'd2;
	localparam logic [2:0] REG_BASELINE    = 3'd3;
	localparam logic [2:0] REG_FIRST_LEVEL = 3'd4;

	typedef struct packed {
		logic [NUM_W-1:0] rem;
		logic [Q_W-1:0]   quo;
	} sdt_lane_t;

	typedef struct packed {
		logic             vld;
		logic             last;
		logic             zero;
		logic             neg_x;
		logic             neg_y;
		logic [DEN_W-1:0] den;
		sdt_lane_t        x;
		sdt_lane_t        y;
		sdt_lane_t        z;
	} sdt_cell_t;

endpackage

// File: design/sdt_front.sv
// Front end: level scaling, centre offset, baseline products and rounding bias.
// Three pipeline stages; feeds the divider chain. Depends on sdt_pkg.
module sdt_front #(
	parameter int unsigned LEVELS = 4
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_vld,
	input  logic [sdt_pkg::PIX_W-1:0]   pixel_u,
	input  logic [sdt_pkg::PIX_W-1:0]   pixel_v,
	input  logic [sdt_pkg::DISP_W-1:0]  disparity,
	input  logic [sdt_pkg::LVL_W-1:0]   pyramid_level,
	input  logic                        last_in_batch,
	input  logic [sdt_pkg::CTR_W-1:0]   center_x,
	input  logic [sdt_pkg::CTR_W-1:0]   center_y,
	input  logic [sdt_pkg::FOC_W-1:0]   focal_length,
	input  logic [sdt_pkg::BASE_W-1:0]  baseline,
	input  logic [sdt_pkg::FL_W-1:0]    first_level,
	output sdt_pkg::sdt_cell_t          dout
);
	import sdt_pkg::*;

	logic [FL_W-1:0]          base;
	logic [LVL_W-1:0]         lvl_c;
	logic [S_W-1:0]           s;
	logic [DIFF_W-1:0]        u_sh, v_sh;

	logic                     vld_s1, vld_s2, vld_s3;
	logic                     last_s1, zero_s1, last_s2, zero_s2;
	logic [DEN_W-1:0]         den_s1, den_s2;
	logic signed [DIFF_W-1:0] dx_s1, dy_s1;

	logic [MAG_W-1:0]         ax, ay;
	logic [MAG_W+BASE_W-1:0]  px_s2, py_s2;
	logic [FOC_W+BASE_W-1:0]  pz_s2;
	logic                     nx_s2, ny_s2;

	sdt_cell_t                pay_s3;

	// stage 1: exponent, denominator, signed offsets
	always_comb begin
		base  = (first_level == '0) ? FL_W'(1) : first_level;
		lvl_c = pyramid_level;
		if (int'(pyramid_level) > int'(LEVELS) - 1)
			lvl_c = LVL_W'(LEVELS - 1);
		s     = S_W'(base) - S_W'(1) + S_W'(lvl_c);
		u_sh  = DIFF_W'(pixel_u) << (s + S_W'(4));
		v_sh  = DIFF_W'(pixel_v) << (s + S_W'(4));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	// stage 2 operands: magnitudes of the offsets
	always_comb begin
		ax = dx_s1[DIFF_W-1] ? MAG_W'(-dx_s1) : MAG_W'(dx_s1);
		ay = dy_s1[DIFF_W-1] ? MAG_W'(-dy_s1) : MAG_W'(dy_s1);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			last_s1 <= last_in_batch;
			zero_s1 <= (disparity == '0);
			den_s1  <= DEN_W'(disparity) << s;
			dx_s1   <= signed'(u_sh) - signed'(DIFF_W'(center_x));
			dy_s1   <= signed'(v_sh) - signed'(DIFF_W'(center_y));

			last_s2 <= last_s1;
			zero_s2 <= zero_s1;
			den_s2  <= den_s1;
			nx_s2   <= dx_s1[DIFF_W-1];
			ny_s2   <= dy_s1[DIFF_W-1];
			px_s2   <= ax * baseline;
			py_s2   <= ay * baseline;
			pz_s2   <= focal_length * baseline;

			// stage 3: add half the denominator for round-to-nearest
			pay_s3.vld   <= vld_s2;
			pay_s3.last  <= last_s2;
			pay_s3.zero  <= zero_s2;
			pay_s3.neg_x <= nx_s2;
			pay_s3.neg_y <= ny_s2;
			pay_s3.den   <= den_s2;
			pay_s3.x.rem <= NUM_W'(px_s2) + NUM_W'(den_s2 >> 1);
			pay_s3.y.rem <= NUM_W'(py_s2) + NUM_W'(den_s2 >> 1);
			pay_s3.z.rem <= NUM_W'(pz_s2) + NUM_W'(den_s2 >> 1);
			pay_s3.x.quo <= '0;
			pay_s3.y.quo <= '0;
			pay_s3.z.quo <= '0;
		end
	end

	always_comb begin
		dout     = pay_s3;
		dout.vld = vld_s3;
	end

endmodule

// File: design/sdt_div_cell.sv
// One cell of the restoring divider chain: resolves quotient bit BIT for three lanes.
// Passes its registered result to the next cell each enabled cycle. Depends on sdt_pkg.
module sdt_div_cell #(
	parameter int unsigned BIT = 0
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  sdt_pkg::sdt_cell_t din,
	output sdt_pkg::sdt_cell_t dout
);
	import sdt_pkg::*;

	logic      vld_q;
	sdt_cell_t data_q;
	sdt_cell_t nxt;

	function automatic sdt_lane_t lane_step(input sdt_lane_t ln, input logic [DEN_W-1:0] den);
		logic [DIV_W-1:0] shd;
		logic             take;
		sdt_lane_t        r;
		shd  = DIV_W'(den) << BIT;
		take = (DIV_W'(ln.rem) >= shd);
		r    = ln;
		if (take) begin
			r.rem = ln.rem - shd[NUM_W-1:0];
			r.quo = ln.quo | (Q_W'(1) << BIT);
		end
		return r;
	endfunction

	always_comb begin
		nxt   = din;
		nxt.x = lane_step(din.x, din.den);
		nxt.y = lane_step(din.y, din.den);
		nxt.z = lane_step(din.z, din.den);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= 1'b0;
		else if (en)
			vld_q <= din.vld;
	end

	always_ff @(posedge clk) begin
		if (en)
			data_q <= nxt;
	end

	always_comb begin
		dout     = data_q;
		dout.vld = vld_q;
	end

endmodule

// File: design/stereo_disparity_triangulation.sv
// Stereo triangulation of feature points: one point in, one X/Y/Z result out.
// Instantiates sdt_front and a chain of sdt_div_cell; depends on sdt_pkg.
//
// Each input transaction is a feature point (column, row, Q8.4 disparity, pyramid level)
// and yields exactly one output transaction with X, Y in signed Q16.16 and Z in
// unsigned Q16.16 metres, all rounded to nearest (ties away from zero) and saturated.
// The principal point and focal length are scaled by 2^-(first_level-1+level);
// a first_level of 0 acts as 1 and a level of LEVELS or more acts as LEVELS-1.
// A zero disparity gives tuser (depth valid) low and all-zero coordinates; tlast
// follows the point. The block takes one point per clock while the pipeline is not
// stalled; from input to output transaction a point passes three front-end stages (scaling,
// baseline multiply, rounding bias), 34 divider cells that each settle one
// quotient bit for all three coordinates, and the output register that applies
// saturation. The whole pipeline advances together whenever the output register
// is free or being read; while it stalls, one more input transaction is held in
// a skid register, so tready on the input side is a register output.
// Registers (APB, byte address 4*i): 0 center_x, 1 center_y, 2 focal_length,
// 3 baseline, 4 first_level. Write them only while no point is in flight.
module stereo_disparity_triangulation #(
	parameter int unsigned LEVELS = 4
) (
	input  logic                         clk,
	input  logic                         arst_n,

	// APB configuration port
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [sdt_pkg::ADDR_W-1:0]   paddr,
	input  logic [sdt_pkg::APB_DW-1:0]   pwdata,
	output logic [sdt_pkg::APB_DW-1:0]   prdata,
	output logic                         pready,

	// input stream
	input  logic                         s_axis_tvalid,
	output logic                         s_axis_tready,
	input  logic [39:0]                  s_axis_tdata,  // pixel_u[11:0], pixel_v[23:12], disparity[35:24], zero[39:36]
	input  logic [1:0]                   s_axis_tuser,  // pyramid_level[1:0]
	input  logic                         s_axis_tlast,  // last_in_batch

	// output stream
	output logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	output logic [95:0]                  m_axis_tdata,  // point_x[31:0], point_y[63:32], point_z[95:64]
	output logic [0:0]                   m_axis_tuser,  // depth_valid[0]
	output logic                         m_axis_tlast   // last_out
);
	import sdt_pkg::*;

	// configuration registers
	logic [CTR_W-1:0]  center_x_q, center_y_q;
	logic [FOC_W-1:0]  focal_q;
	logic [BASE_W-1:0] baseline_q;
	logic [FL_W-1:0]   first_level_q;
	logic [2:0]        reg_idx;
	logic              cfg_wr;

	// skid register on the input side
	logic              skid_vld_q;
	logic [PIX_W-1:0]  skid_u_q, skid_v_q;
	logic [DISP_W-1:0] skid_d_q;
	logic [LVL_W-1:0]  skid_lvl_q;
	logic              skid_last_q;

	// pipeline feed
	logic              en;
	logic              feed_vld;
	logic [PIX_W-1:0]  feed_u, feed_v;
	logic [DISP_W-1:0] feed_d;
	logic [LVL_W-1:0]  feed_lvl;
	logic              feed_last;

	sdt_cell_t         chain [Q_W+1];
	sdt_cell_t         tail;

	// output register
	logic                out_vld_q;
	logic [COORD_W-1:0]  pt_x_q, pt_y_q, pt_z_q;
	logic                dv_q, last_q;
	logic [COORD_W-1:0]  sat_x, sat_y, sat_z;

	// signed result from magnitude quotient; guard bits above bit 31 mean overflow
	function automatic logic [COORD_W-1:0] sat_signed(input logic [Q_W-1:0] q, input logic neg);
		logic big_pos;
		logic big_neg;
		big_pos = |q[Q_W-1:COORD_W-1];
		big_neg = (|q[Q_W-1:COORD_W]) || (q[COORD_W-1] && (|q[COORD_W-2:0]));
		if (neg)
			return big_neg ? {1'b1, {(COORD_W-1){1'b0}}} : (~q[COORD_W-1:0]) + COORD_W'(1);
		return big_pos ? {1'b0, {(COORD_W-1){1'b1}}} : q[COORD_W-1:0];
	endfunction

	// ---------------- configuration ----------------
	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q    <= '0;
			center_y_q    <= '0;
			focal_q       <= '0;
			baseline_q    <= '0;
			first_level_q <= FL_W'(1);
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_CENTER_X:    center_x_q    <= pwdata[CTR_W-1:0];
				REG_CENTER_Y:    center_y_q    <= pwdata[CTR_W-1:0];
				REG_FOCAL:       focal_q       <= pwdata[FOC_W-1:0];
				REG_BASELINE:    baseline_q    <= pwdata[BASE_W-1:0];
				REG_FIRST_LEVEL: first_level_q <= pwdata[FL_W-1:0];
				default: ;  // unmapped: write dropped
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_CENTER_X:    prdata = APB_DW'(center_x_q);
			REG_CENTER_Y:    prdata = APB_DW'(center_y_q);
			REG_FOCAL:       prdata = APB_DW'(focal_q);
			REG_BASELINE:    prdata = APB_DW'(baseline_q);
			REG_FIRST_LEVEL: prdata = APB_DW'(first_level_q);
			default:         prdata = '0;
		endcase
	end

	// ---------------- input skid ----------------
	// global advance: output register empty or being drained
	assign en            = !out_vld_q || m_axis_tready;
	assign s_axis_tready = !skid_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			skid_vld_q <= 1'b0;
		else if (en)
			skid_vld_q <= 1'b0;                 // held transaction enters the front end
		else if (s_axis_tvalid && !skid_vld_q)
			skid_vld_q <= 1'b1;                 // pipeline frozen: park it
	end

	always_ff @(posedge clk) begin
		if (!en && !skid_vld_q) begin
			skid_u_q    <= s_axis_tdata[11:0];
			skid_v_q    <= s_axis_tdata[23:12];
			skid_d_q    <= s_axis_tdata[35:24];
			skid_lvl_q  <= s_axis_tuser;
			skid_last_q <= s_axis_tlast;
		end
	end

	always_comb begin
		if (skid_vld_q) begin
			feed_vld  = 1'b1;
			feed_u    = skid_u_q;
			feed_v    = skid_v_q;
			feed_d    = skid_d_q;
			feed_lvl  = skid_lvl_q;
			feed_last = skid_last_q;
		end else begin
			feed_vld  = s_axis_tvalid;
			feed_u    = s_axis_tdata[11:0];
			feed_v    = s_axis_tdata[23:12];
			feed_d    = s_axis_tdata[35:24];
			feed_lvl  = s_axis_tuser;
			feed_last = s_axis_tlast;
		end
	end

	// ---------------- datapath ----------------
	sdt_front #(
		.LEVELS(LEVELS)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.en            (en),
		.in_vld        (feed_vld),
		.pixel_u       (feed_u),
		.pixel_v       (feed_v),
		.disparity     (feed_d),
		.pyramid_level (feed_lvl),
		.last_in_batch (feed_last),
		.center_x      (center_x_q),
		.center_y      (center_y_q),
		.focal_length  (focal_q),
		.baseline      (baseline_q),
		.first_level   (first_level_q),
		.dout          (chain[0])
	);

	// quotient bits settle MSB first, one per cell
	for (genvar i = 0; i < Q_W; i++) begin : g_cell
		sdt_div_cell #(
			.BIT(Q_W - 1 - i)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.din    (chain[i]),
			.dout   (chain[i+1])
		);
	end

	assign tail = chain[Q_W];

	always_comb begin
		sat_x = sat_signed(tail.x.quo, tail.neg_x);
		sat_y = sat_signed(tail.y.quo, tail.neg_y);
		sat_z = (|tail.z.quo[Q_W-1:COORD_W]) ? '1 : tail.z.quo[COORD_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_vld_q <= 1'b0;
		else if (en)
			out_vld_q <= tail.vld;
	end

	// zero disparity: divider ran on a zero denominator, force the result clean
	always_ff @(posedge clk) begin
		if (en) begin
			pt_x_q <= tail.zero ? '0 : sat_x;
			pt_y_q <= tail.zero ? '0 : sat_y;
			pt_z_q <= tail.zero ? '0 : sat_z;
			dv_q   <= !tail.zero;
			last_q <= tail.last;
		end
	end

	assign m_axis_tvalid   = out_vld_q;
	assign m_axis_tdata    = {pt_z_q, pt_y_q, pt_x_q};
	assign m_axis_tuser[0] = dv_q;
	assign m_axis_tlast    = last_q;

`ifndef ASSERT_OFF
	// a parked transaction is kept until the pipeline moves again
	a_skid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q && !en |=> skid_vld_q)
		else $error("skid transaction dropped during stall");

	// a transaction taken while the pipeline is frozen must land in the skid
	a_skid_load: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && !en |=> skid_vld_q)
		else $error("input transaction lost during stall");

	// points without depth carry zero coordinates
	a_zero_point: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == '0)
		else $error("invalid point with nonzero coordinates");
`endif

endmodule
